### rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int TAB_SPACES = 4;
    localparam int TAB_W      = $clog2(TAB_SPACES);

    localparam logic [7:0] SPACE_CODE  = 8'h20;
    localparam logic [7:0] LINE_FEED   = 8'd10;
    localparam logic [7:0] TAB_CODE    = 8'd9;
    localparam logic [7:0] COLOR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        K_PUT   = 2'd0,
        K_CLEAR = 2'd1,
        K_READ  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic load_item;
        logic sweep_all;
        logic sweep_row;
        logic sweep_step;
        logic put_glyph;
        logic new_line;
        logic rd_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  is_lf;
        logic  is_tab;
        logic  rd_in_range;
        logic  sweep_last;
        logic  at_eol;
        logic  at_bottom;
        logic  out_free;
    } t_status;

endpackage

### rtl/text_console_writer.sv
// channel   | dir | signals                        | contents (low bit first)
// ----------+-----+--------------------------------+---------------------------------------
// s_axis    | in  | tvalid tready tdata[23:0] tuser | tdata: char_code, read_col, read_row
//           |     |                                | tuser: kind
// m_axis    | out | tvalid tready tdata[31:0]      | cell_char, cell_color, cursor_col,
//           |     |                                | cursor_row
// config    | in  | i_cfg_we i_cfg_wdata[7:0]      | text_color
//
// one item at a time: a glyph or in-range read passes accept, decode, write or read, output load;
// a line feed, out-of-range read or unused kind skips the write or read; a tab writes 4 spaces.
// a scroll blanks one row of 80 cells through the single cell memory write port.
// a clear sweeps all 2000 cells through the same port.
// after reset the store is swept to spaces, all 2000 cells, with s_axis_tready low.
// a stalled result waits in the output register while the next item is accepted.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // text_color
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // char_code[7:0], read_col[14:8], read_row[19:15]
    input  logic [1:0]  s_axis_tuser,    // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // cell_char, cell_color, cursor_col, cursor_row
);

    t_cmd             cmd;
    t_status          status;
    logic [7:0]       cell_char, cell_color;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_kind       (s_axis_tuser),
        .i_char       (s_axis_tdata[7:0]),
        .i_col        (s_axis_tdata[14:8]),
        .i_row        (s_axis_tdata[19:15]),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_cell_char  (cell_char),
        .o_cell_color (cell_color),
        .o_cursor_col (cursor_col),
        .o_cursor_row (cursor_row)
    );

    assign m_axis_tdata = {4'h0, cursor_row, cursor_col, cell_color, cell_char};

    // an accepted item holds off the next one until its work is done
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:16] < COL_W'(COLUMNS)) &&
                          (m_axis_tdata[27:23] < ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    // the store sweep after reset keeps the input closed
    a_init_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

endmodule

### rtl/tcw_dp.sv
module tcw_dp
    import tcw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_char,
    input  logic [COL_W-1:0] i_col,
    input  logic [ROW_W-1:0] i_row,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_cell_char,
    output logic [7:0]       o_cell_color,
    output logic [COL_W-1:0] o_cursor_col,
    output logic [ROW_W-1:0] o_cursor_row
);

    t_kind              r_kind;
    logic [7:0]         r_char;
    logic [COL_W-1:0]   r_rcol;
    logic [ROW_W-1:0]   r_rrow;
    logic [COL_W-1:0]   r_x, n_x;
    logic [ROW_W-1:0]   r_y, n_y;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [7:0]         r_color;
    logic [ADDR_W-1:0]  r_sweep_addr, r_sweep_end;
    logic [15:0]        r_rd_data;
    logic [15:0]        r_mem [CELLS];
    logic               r_out_valid;
    logic [7:0]         r_out_char, r_out_color;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;

    logic [ROW_W:0]     cur_sum, rd_sum;
    logic [ROW_W-1:0]   cur_prow, rd_prow;
    logic [ADDR_W-1:0]  cur_addr, rd_addr, row_start;
    logic [ADDR_W-1:0]  wr_addr;
    logic [15:0]        wr_data;
    logic               wr_en;
    logic [7:0]         glyph;
    logic               rd_ok;

    // rotating top row: physical row = (top + row) mod ROWS, both below ROWS
    always_comb begin
        cur_sum  = {1'b0, r_top} + {1'b0, r_y};
        cur_prow = (cur_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(cur_sum - (ROW_W+1)'(ROWS))
                                                 : ROW_W'(cur_sum);
        rd_sum   = {1'b0, r_top} + {1'b0, r_rrow};
        rd_prow  = (rd_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W+1)'(ROWS))
                                                : ROW_W'(rd_sum);
        cur_addr  = ADDR_W'(cur_prow) * ADDR_W'(COLUMNS) + ADDR_W'(r_x);
        rd_addr   = ADDR_W'(rd_prow) * ADDR_W'(COLUMNS) + ADDR_W'(r_rcol);
        row_start = ADDR_W'(r_top) * ADDR_W'(COLUMNS);
    end

    assign rd_ok = (r_rcol < COL_W'(COLUMNS)) && (r_rrow < ROW_W'(ROWS));
    assign glyph = (r_char == TAB_CODE) ? SPACE_CODE : r_char;

    assign wr_en   = i_cmd.sweep_step | i_cmd.put_glyph;
    assign wr_addr = i_cmd.put_glyph ? cur_addr : r_sweep_addr;
    assign wr_data = i_cmd.put_glyph ? {r_color, glyph} : {8'h00, SPACE_CODE};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind <= t_kind'(i_kind);
            r_char <= i_char;
            r_rcol <= i_col;
            r_rrow <= i_row;
        end
    end

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_top = r_top;
        if (i_cmd.put_glyph) begin
            n_x = r_x + COL_W'(1);
        end
        if (i_cmd.new_line) begin
            n_x = '0;
            if (r_y < ROW_W'(ROWS - 1)) begin
                n_y = r_y + ROW_W'(1);
            end else begin
                n_top = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x          <= '0;
            r_y          <= '0;
            r_top        <= '0;
            r_color      <= COLOR_RESET;
            r_sweep_addr <= '0;
            r_sweep_end  <= ADDR_W'(CELLS - 1);
            r_out_valid  <= 1'b0;
        end else begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_top <= n_top;
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (i_cmd.sweep_all) begin
                r_sweep_addr <= '0;
                r_sweep_end  <= ADDR_W'(CELLS - 1);
            end else if (i_cmd.sweep_row) begin
                // old top row becomes the new bottom row
                r_sweep_addr <= row_start;
                r_sweep_end  <= row_start + ADDR_W'(COLUMNS - 1);
            end else if (i_cmd.sweep_step) begin
                r_sweep_addr <= r_sweep_addr + ADDR_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_kind == K_READ && rd_ok) begin
                r_out_char  <= r_rd_data[7:0];
                r_out_color <= r_rd_data[15:8];
            end else begin
                r_out_char  <= '0;
                r_out_color <= '0;
            end
            r_out_col <= r_x;
            r_out_row <= r_y;
        end
    end

    always_comb begin
        o_status.kind        = r_kind;
        o_status.is_lf       = (r_char == LINE_FEED);
        o_status.is_tab      = (r_char == TAB_CODE);
        o_status.rd_in_range = rd_ok;
        o_status.sweep_last  = (r_sweep_addr == r_sweep_end);
        o_status.at_eol      = (r_x == COL_W'(COLUMNS - 1));
        o_status.at_bottom   = (r_y == ROW_W'(ROWS - 1));
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_char;
    assign o_cell_color = r_out_color;
    assign o_cursor_col = r_out_col;
    assign o_cursor_row = r_out_row;

endmodule

### rtl/tcw_ctrl.sv
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_DECODE = 8'b0000_0100,
        S_PUT    = 8'b0000_1000,
        S_BLANK  = 8'b0001_0000,
        S_CLEAR  = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [TAB_W-1:0] r_tab, n_tab;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_tab      = r_tab;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.kind)
                    K_PUT: begin
                        n_tab = '0;
                        if (i_status.is_lf) begin
                            o_cmd.new_line = 1'b1;
                            if (i_status.at_bottom) begin
                                o_cmd.sweep_row = 1'b1;
                                n_state         = S_BLANK;
                            end else begin
                                n_state = S_OUT;
                            end
                        end else begin
                            if (i_status.is_tab) begin
                                n_tab = TAB_W'(TAB_SPACES - 1);
                            end
                            n_state = S_PUT;
                        end
                    end
                    K_CLEAR: begin
                        o_cmd.sweep_all = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    K_READ: begin
                        n_state = i_status.rd_in_range ? S_READ : S_OUT;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_PUT: begin
                o_cmd.put_glyph = 1'b1;
                o_cmd.new_line  = i_status.at_eol;
                if (i_status.at_eol && i_status.at_bottom) begin
                    o_cmd.sweep_row = 1'b1;
                    n_state         = S_BLANK;
                end else if (r_tab != '0) begin
                    n_tab   = r_tab - TAB_W'(1);
                    n_state = S_PUT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_BLANK: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    // a tab may still have spaces to write after the scroll
                    if (r_tab != '0) begin
                        n_tab   = r_tab - TAB_W'(1);
                        n_state = S_PUT;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = S_OUT;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_tab   <= '0;
        end else begin
            r_state <= n_state;
            r_tab   <= n_tab;
        end
    end

endmodule

### tb/console_checker.sv
`timescale 1ns / 100ps

module console_checker
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // text_color
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // char_code[7:0], read_col[14:8], read_row[19:15]
    input  logic [1:0]  s_axis_tuser,    // kind
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,    // cell_char, cell_color, cursor_col, cursor_row
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [7:0]       cell_char;
        logic [7:0]       cell_color;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
    } t_console_reply;

    // screen image: color in the high byte, character in the low byte
    logic [15:0]    screen [CELLS];
    int             cur_col;
    int             cur_row;
    int             top_row;
    logic [7:0]     ink;
    int             mismatches;
    t_console_reply console_replies[$];

    function automatic void blank_row(int phys_row);
        for (int c = 0; c < COLUMNS; c++) begin
            screen[phys_row * COLUMNS + c] = {8'h00, SPACE_CODE};
        end
    endfunction

    // bottom row: rotate the top offset and blank the row that falls off
    function automatic void advance_line();
        if (cur_row < ROWS - 1) begin
            cur_row++;
        end else begin
            blank_row(top_row);
            top_row = (top_row + 1) % ROWS;
        end
        cur_col = 0;
    endfunction

    function automatic void place_glyph(logic [7:0] code);
        screen[((top_row + cur_row) % ROWS) * COLUMNS + cur_col] = {ink, code};
        cur_col++;
        if (cur_col >= COLUMNS) begin
            advance_line();
        end
    endfunction

    function automatic t_console_reply apply_item(t_kind kind, logic [7:0] code,
                                                  int col, int row);
        t_console_reply reply;
        logic [15:0]    stored;
        reply = '{default: '0};
        case (kind)
            K_PUT: begin
                if (code == LINE_FEED) begin
                    advance_line();
                end else if (code == TAB_CODE) begin
                    for (int i = 0; i < TAB_SPACES; i++) begin
                        place_glyph(SPACE_CODE);
                    end
                end else begin
                    place_glyph(code);
                end
            end
            K_CLEAR: begin
                for (int r = 0; r < ROWS; r++) begin
                    blank_row(r);
                end
            end
            K_READ: begin
                if (col < COLUMNS && row < ROWS) begin
                    stored = screen[((top_row + row) % ROWS) * COLUMNS + col];
                    reply.cell_char  = stored[7:0];
                    reply.cell_color = stored[15:8];
                end
            end
            default: begin
            end
        endcase
        reply.cursor_col = cur_col[COL_W-1:0];
        reply.cursor_row = cur_row[ROW_W-1:0];
        return reply;
    endfunction

    always @(posedge i_clk) begin : watch
        t_console_reply got;
        t_console_reply want;
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                blank_row(r);
            end
            cur_col = 0;
            cur_row = 0;
            top_row = 0;
            ink     = COLOR_RESET;
            console_replies.delete();
        end else begin
            if (i_cfg_we) begin
                ink = i_cfg_wdata;
            end
            // results are checked before the item of this edge is added
            if (m_axis_tvalid && m_axis_tready) begin
                got.cell_char  = m_axis_tdata[7:0];
                got.cell_color = m_axis_tdata[15:8];
                got.cursor_col = m_axis_tdata[22:16];
                got.cursor_row = m_axis_tdata[27:23];
                if (console_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("console: unexpected result %h at %0t", m_axis_tdata, $time);
                    end
                end else begin
                    want = console_replies.pop_front();
                    if (got.cell_char !== want.cell_char
                            || got.cell_color !== want.cell_color
                            || got.cursor_col !== want.cursor_col
                            || got.cursor_row !== want.cursor_row) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("console: mismatch at %0t (expected/actual)", $time);
                            $display("  char %h/%h color %h/%h col %0d/%0d row %0d/%0d",
                                     want.cell_char, got.cell_char,
                                     want.cell_color, got.cell_color,
                                     want.cursor_col, got.cursor_col,
                                     want.cursor_row, got.cursor_row);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                console_replies.push_back(apply_item(t_kind'(s_axis_tuser),
                                                     s_axis_tdata[7:0],
                                                     int'(s_axis_tdata[14:8]),
                                                     int'(s_axis_tdata[19:15])));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= console_replies.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tcw_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [7:0]  i_cfg_wdata   = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;    // char_code[7:0], read_col[14:8], read_row[19:15]
    logic [1:0]  s_axis_tuser  = '0;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // cell_char, cell_color, cursor_col, cursor_row

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    text_console_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    console_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // returns at the edge that accepted the item, tvalid still high
    task automatic send_item(t_kind kind, logic [7:0] code,
                             logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, row, col, code};
        s_axis_tuser  <= kind;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if (kind != K_NONE) begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_ink(logic [7:0] color);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= color;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic put_text_line();
        int         n;
        int         r;
        logic [7:0] code;
        n = ($urandom_range(9) == 0) ? $urandom_range(80, 170) : $urandom_range(0, 60);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 6) begin
                code = TAB_CODE;
            end else if (r < 10) begin
                code = 8'($urandom_range(0, 255));
            end else begin
                code = 8'($urandom_range(32, 126));
            end
            send_item(K_PUT, code, COL_W'($urandom_range(0, 127)),
                      ROW_W'($urandom_range(0, 31)));
        end
        if ($urandom_range(3) != 0) begin
            send_item(K_PUT, LINE_FEED, COL_W'($urandom_range(0, 127)),
                      ROW_W'($urandom_range(0, 31)));
        end
    endtask

    task automatic read_cells();
        int               n;
        int               r;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            // the cursor settles on the bottom rows, so most reads look there
            if (r < 50) begin
                col = COL_W'($urandom_range(0, COLUMNS - 1));
                row = ROW_W'($urandom_range(ROWS - 5, ROWS - 1));
            end else if (r < 90) begin
                col = COL_W'($urandom_range(0, COLUMNS - 1));
                row = ROW_W'($urandom_range(0, ROWS - 1));
            end else begin
                col = COL_W'($urandom_range(0, 127));
                row = ROW_W'($urandom_range(0, 31));
            end
            send_item(K_READ, 8'($urandom_range(0, 255)), col, row);
        end
    endtask

    task automatic random_burst();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 50) begin
            put_text_line();
        end else if (pick < 75) begin
            read_cells();
        end else if (pick < 82) begin
            send_item($urandom_range(0, 1) ? K_NONE : K_PUT, 8'($urandom_range(0, 255)),
                      COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
        end else if (pick < 85) begin
            send_item(K_CLEAR, 8'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                      ROW_W'($urandom_range(0, 31)));
        end else begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) begin
                send_item(K_PUT, LINE_FEED, COL_W'($urandom_range(0, 127)),
                          ROW_W'($urandom_range(0, 31)));
            end
        end
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int quota,
                             logic [7:0] color_a, logic [7:0] color_b);
        int stop;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int half = 0; half < 2; half++) begin
            load_ink(half == 0 ? color_a : color_b);
            stop = items_sent + quota / 2;
            while (items_sent < stop) begin
                random_burst();
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, still with the reset color
        send_item(K_READ, 8'h00, 7'd0, 5'd0);
        send_item(K_PUT, 8'h48, 7'd0, 5'd0);
        send_item(K_PUT, 8'h00, 7'd0, 5'd0);
        send_item(K_PUT, 8'hFF, 7'd127, 5'd31);
        send_item(K_PUT, TAB_CODE, 7'd0, 5'd0);
        send_item(K_READ, 8'h00, 7'd0, 5'd0);
        send_item(K_READ, 8'h00, 7'd2, 5'd0);
        send_item(K_READ, 8'h00, 7'd6, 5'd0);
        send_item(K_PUT, LINE_FEED, 7'd0, 5'd0);
        send_item(K_PUT, 8'h7E, 7'd0, 5'd0);
        send_item(K_READ, 8'hFF, 7'd0, 5'd1);
        send_item(K_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
        // reads outside the screen
        send_item(K_READ, 8'h00, COL_W'(COLUMNS), 5'd0);
        send_item(K_READ, 8'h00, 7'd127, 5'd31);
        send_item(K_READ, 8'h00, 7'd0, ROW_W'(ROWS));
        // unused kind
        send_item(K_NONE, 8'hFF, 7'd127, 5'd31);
        send_item(K_NONE, 8'h00, 7'd0, 5'd0);
        send_item(K_CLEAR, 8'h00, 7'd0, 5'd0);
        send_item(K_READ, 8'h00, 7'd0, 5'd0);
        send_item(K_READ, 8'h00, 7'd1, 5'd1);
        send_item(K_PUT, 8'h5A, 7'd0, 5'd0);
        send_item(K_READ, 8'h00, 7'd1, 5'd1);

        run_phase(23, 80, 640, 8'h00, 8'hFF);
        run_phase(80, 23, 640, 8'($urandom_range(1, 254)), 8'h80);
        run_phase(0, 0, 620, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
